>>> sv/tlc_pkg.sv
`timescale 1ns / 1ps
package tlc_pkg;

	localparam int ADDR_W = 10;
	localparam int DATA_W = 8;
	localparam int COST_W = 8;
	localparam int LAT_W = 10;
	localparam int CFG_IDX_W = 2;

	localparam logic [LAT_W-1:0] LAT_MAX = 10'd1023;

	localparam logic OP_READ = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_HIT_COST = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MISS_COST = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WRITE_COST = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_COST = 2'd3;

	localparam logic [COST_W-1:0] HIT_COST_RST = 8'd1;
	localparam logic [COST_W-1:0] MISS_COST_RST = 8'd5;
	localparam logic [COST_W-1:0] WRITE_COST_RST = 8'd10;
	localparam logic [COST_W-1:0] MEMORY_COST_RST = 8'd50;

	typedef struct packed {
		logic opcode;
		logic [ADDR_W-1:0] address;
		logic [DATA_W-1:0] write_data;
	} in_item_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic first_hit;
		logic second_hit;
		logic [LAT_W-1:0] latency;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear;
		logic load;
		logic quot;
		logic look;
		logic commit;
	} tlc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_last;
		logic out_free;
	} tlc_sts_t;

endpackage

>>> sv/two_level_write_through_cache.sv
`timescale 1ns / 1ps
// Two-level direct-mapped write-through byte cache in front of a byte main
// memory. Each input transfer is one read or write of a byte; each produces
// exactly one output transfer with the read byte, the hit flags of both levels
// and the cost-weighted latency. A read that misses the near level fills it,
// and fills the far level too when that also misses; a write updates only
// lines that hit and always writes memory. After reset the block runs a
// clearing pass, zeroing main memory and invalidating both levels, and takes
// no input transfer until it ends; cost registers can be written at any time.
// An access then passes through these steps, the first in the cycle of its
// input transfer: address wrap, tag computation by reciprocal multiply, index
// computation with the read of all three memories, and the hit check with the
// memory update. The result is offered once the hit check loads it into the
// output register; that step waits while the previous result still waits
// there. One access is in flight at a time; the next input transfer is taken
// in the cycle after the result is loaded, while that result may still wait in
// the output register.
module two_level_write_through_cache
	import tlc_pkg::*;
#(
	parameter int MEM_DEPTH = 1024,
	parameter int NEAR_ENTRIES = 32,
	parameter int FAR_ENTRIES = 128
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COST_W-1:0]    cfg_data
);

	tlc_cmd_t cmd;
	tlc_sts_t sts;

	tlc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts(sts),
		.cmd(cmd)
	);

	tlc_dp #(
		.MEM_DEPTH(MEM_DEPTH),
		.NEAR_ENTRIES(NEAR_ENTRIES),
		.FAR_ENTRIES(FAR_ENTRIES)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.in_data(in_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.out_data(out_data)
	);

	// A result is never loaded over one that has not been transferred.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid || out_ready))
		else $error("result loaded over a pending output");

	// Only one access is in flight at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while an access is in flight");

	// A loaded result is offered in the following cycle.
	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid)
		else $error("loaded result not offered");

	// No result is loaded and no input is taken during the clearing pass.
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |-> (!in_ready && !cmd.commit))
		else $error("activity during clearing pass");

endmodule

>>> sv/tlc_ram.sv
`timescale 1ns / 1ps
module tlc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> sv/tlc_ctrl.sv
`timescale 1ns / 1ps
module tlc_ctrl
	import tlc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  tlc_sts_t sts,
	output tlc_cmd_t cmd
);

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_QUOT  = 5'b00100,
		S_LOOK  = 5'b01000,
		S_UPD   = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_QUOT;
				end
			end
			S_QUOT: begin
				cmd.quot = 1'b1;
				state_d = S_LOOK;
			end
			S_LOOK: begin
				cmd.look = 1'b1;
				state_d = S_UPD;
			end
			S_UPD: begin
				// An access updates memory only in the cycle its result is loaded.
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> sv/tlc_dp.sv
`timescale 1ns / 1ps
module tlc_dp
	import tlc_pkg::*;
#(
	parameter int MEM_DEPTH = 1024,
	parameter int NEAR_ENTRIES = 32,
	parameter int FAR_ENTRIES = 128
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tlc_cmd_t             cmd,
	output tlc_sts_t             sts,
	input  in_item_t             in_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COST_W-1:0]    cfg_data,
	input  logic                 out_ready,
	output logic                 out_valid,
	output out_item_t            out_data
);

	localparam int SPAN = (MEM_DEPTH < (1 << ADDR_W)) ? MEM_DEPTH : (1 << ADDR_W);
	localparam int MEM_AW = $clog2(MEM_DEPTH);
	localparam int NEAR_IW = $clog2(NEAR_ENTRIES);
	localparam int FAR_IW = $clog2(FAR_ENTRIES);
	localparam int NEAR_TAGS = (SPAN + NEAR_ENTRIES - 1) / NEAR_ENTRIES;
	localparam int FAR_TAGS = (SPAN + FAR_ENTRIES - 1) / FAR_ENTRIES;
	localparam int NEAR_TW = (NEAR_TAGS > 1) ? $clog2(NEAR_TAGS) : 1;
	localparam int FAR_TW = (FAR_TAGS > 1) ? $clog2(FAR_TAGS) : 1;
	localparam int NEAR_LW = 1 + NEAR_TW + DATA_W;
	localparam int FAR_LW = 1 + FAR_TW + DATA_W;

	// Division by the entry counts is a multiply by a rounded-up reciprocal,
	// exact for every address of ADDR_W bits.
	localparam int MUL_W = ADDR_W + 2;
	localparam int PROD_W = ADDR_W + MUL_W;
	localparam int NEAR_SH = ADDR_W + $clog2(NEAR_ENTRIES);
	localparam int FAR_SH = ADDR_W + $clog2(FAR_ENTRIES);
	localparam logic [MUL_W-1:0] NEAR_MUL =
		MUL_W'((64'd1 << NEAR_SH) / NEAR_ENTRIES + 64'd1);
	localparam logic [MUL_W-1:0] FAR_MUL =
		MUL_W'((64'd1 << FAR_SH) / FAR_ENTRIES + 64'd1);

	localparam int CLR_N0 = (MEM_DEPTH > NEAR_ENTRIES) ? MEM_DEPTH : NEAR_ENTRIES;
	localparam int CLR_N = (CLR_N0 > FAR_ENTRIES) ? CLR_N0 : FAR_ENTRIES;
	localparam int CLR_W = $clog2(CLR_N);

	// Cost registers.
	logic [COST_W-1:0] hit_cost_q;
	logic [COST_W-1:0] miss_cost_q;
	logic [COST_W-1:0] write_cost_q;
	logic [COST_W-1:0] memory_cost_q;

	logic [CLR_W-1:0] clr_cnt_q;
	logic out_valid_q;
	out_item_t out_q;

	logic op_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [DATA_W-1:0] wd_s1;
	logic [NEAR_TW-1:0] nt_s2;
	logic [FAR_TW-1:0] ft_s2;
	logic [NEAR_IW-1:0] ni_s3;
	logic [FAR_IW-1:0] fi_s3;

	logic [16:0] mod_v;
	logic [PROD_W-1:0] near_prod;
	logic [PROD_W-1:0] far_prod;
	logic [NEAR_IW-1:0] ni_c;
	logic [FAR_IW-1:0] fi_c;

	logic near_we;
	logic [NEAR_IW-1:0] near_waddr;
	logic [NEAR_LW-1:0] near_wdata;
	logic [NEAR_LW-1:0] near_rdata;
	logic far_we;
	logic [FAR_IW-1:0] far_waddr;
	logic [FAR_LW-1:0] far_wdata;
	logic [FAR_LW-1:0] far_rdata;
	logic main_we;
	logic [MEM_AW-1:0] main_waddr;
	logic [DATA_W-1:0] main_wdata;
	logic [DATA_W-1:0] main_rdata;

	logic nhit;
	logic fhit;
	logic [DATA_W-1:0] rd_byte;
	logic [DATA_W-1:0] fill_byte;
	logic near_upd;
	logic far_upd;
	logic [LAT_W:0] lat_sum;
	out_item_t res;

	// The address is below 1024, so three conditional subtractions wrap it when
	// the memory holds at least 256 bytes, which the block does not check.
	always_comb begin
		mod_v = 17'(in_data.address);
		for (int i = 0; i < 3; i++) begin
			if (mod_v >= 17'(MEM_DEPTH)) begin
				mod_v = mod_v - 17'(MEM_DEPTH);
			end
		end
	end

	assign near_prod = PROD_W'(addr_s1) * PROD_W'(NEAR_MUL);
	assign far_prod = PROD_W'(addr_s1) * PROD_W'(FAR_MUL);

	assign ni_c = NEAR_IW'(32'(addr_s1) - 32'(nt_s2) * 32'(NEAR_ENTRIES));
	assign fi_c = FAR_IW'(32'(addr_s1) - 32'(ft_s2) * 32'(FAR_ENTRIES));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_s1 <= in_data.opcode;
			addr_s1 <= ADDR_W'(mod_v);
			wd_s1 <= in_data.write_data;
		end
		if (cmd.quot) begin
			nt_s2 <= NEAR_TW'(near_prod >> NEAR_SH);
			ft_s2 <= FAR_TW'(far_prod >> FAR_SH);
		end
		if (cmd.look) begin
			ni_s3 <= ni_c;
			fi_s3 <= fi_c;
		end
		if (cmd.commit) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_cost_q <= HIT_COST_RST;
			miss_cost_q <= MISS_COST_RST;
			write_cost_q <= WRITE_COST_RST;
			memory_cost_q <= MEMORY_COST_RST;
			clr_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_HIT_COST: hit_cost_q <= cfg_data;
					CFG_MISS_COST: miss_cost_q <= cfg_data;
					CFG_WRITE_COST: write_cost_q <= cfg_data;
					CFG_MEMORY_COST: memory_cost_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (cmd.clear) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.clear_last = (clr_cnt_q == CLR_W'(CLR_N - 1));
	assign sts.out_free = !out_valid_q || out_ready;

	// Lookup results; the stored line is {valid, tag, byte}.
	assign nhit = near_rdata[NEAR_LW-1] && (near_rdata[DATA_W +: NEAR_TW] == nt_s2);
	assign fhit = far_rdata[FAR_LW-1] && (far_rdata[DATA_W +: FAR_TW] == ft_s2);

	always_comb begin
		if (nhit) begin
			rd_byte = near_rdata[DATA_W-1:0];
		end else if (fhit) begin
			rd_byte = far_rdata[DATA_W-1:0];
		end else begin
			rd_byte = main_rdata;
		end
	end

	always_comb begin
		if (op_s1 == OP_WRITE) begin
			fill_byte = wd_s1;
			near_upd = nhit;
			far_upd = fhit;
			lat_sum = (LAT_W + 1)'(write_cost_q) + (LAT_W + 1)'(write_cost_q)
				+ (nhit ? (LAT_W + 1)'(hit_cost_q) : '0)
				+ (fhit ? (LAT_W + 1)'(hit_cost_q) : '0);
			res.read_data = '0;
			res.second_hit = fhit;
		end else begin
			fill_byte = rd_byte;
			near_upd = !nhit;
			far_upd = !nhit && !fhit;
			if (nhit) begin
				lat_sum = (LAT_W + 1)'(hit_cost_q);
			end else if (fhit) begin
				lat_sum = (LAT_W + 1)'(miss_cost_q) + (LAT_W + 1)'(hit_cost_q);
			end else begin
				lat_sum = (LAT_W + 1)'(miss_cost_q) + (LAT_W + 1)'(miss_cost_q)
					+ (LAT_W + 1)'(memory_cost_q);
			end
			res.read_data = rd_byte;
			res.second_hit = !nhit && fhit;
		end
		res.first_hit = nhit;
		res.latency = (lat_sum > (LAT_W + 1)'(LAT_MAX)) ? LAT_MAX : lat_sum[LAT_W-1:0];
	end

	// The clearing pass writes zeros to every entry of every store.
	always_comb begin
		if (cmd.clear) begin
			near_we = 32'(clr_cnt_q) < NEAR_ENTRIES;
			near_waddr = clr_cnt_q[NEAR_IW-1:0];
			near_wdata = '0;
			far_we = 32'(clr_cnt_q) < FAR_ENTRIES;
			far_waddr = clr_cnt_q[FAR_IW-1:0];
			far_wdata = '0;
			main_we = 32'(clr_cnt_q) < MEM_DEPTH;
			main_waddr = clr_cnt_q[MEM_AW-1:0];
			main_wdata = '0;
		end else begin
			near_we = cmd.commit && near_upd;
			near_waddr = ni_s3;
			near_wdata = {1'b1, nt_s2, fill_byte};
			far_we = cmd.commit && far_upd;
			far_waddr = fi_s3;
			far_wdata = {1'b1, ft_s2, fill_byte};
			main_we = cmd.commit && (op_s1 == OP_WRITE);
			main_waddr = MEM_AW'(addr_s1);
			main_wdata = wd_s1;
		end
	end

	tlc_ram #(
		.WIDTH(NEAR_LW),
		.DEPTH(NEAR_ENTRIES)
	) u_near_ram (
		.clk(clk),
		.we(near_we),
		.waddr(near_waddr),
		.wdata(near_wdata),
		.re(cmd.look),
		.raddr(ni_c),
		.rdata(near_rdata)
	);

	tlc_ram #(
		.WIDTH(FAR_LW),
		.DEPTH(FAR_ENTRIES)
	) u_far_ram (
		.clk(clk),
		.we(far_we),
		.waddr(far_waddr),
		.wdata(far_wdata),
		.re(cmd.look),
		.raddr(fi_c),
		.rdata(far_rdata)
	);

	tlc_ram #(
		.WIDTH(DATA_W),
		.DEPTH(MEM_DEPTH)
	) u_main_ram (
		.clk(clk),
		.we(main_we),
		.waddr(main_waddr),
		.wdata(main_wdata),
		.re(cmd.look),
		.raddr(MEM_AW'(addr_s1)),
		.rdata(main_rdata)
	);

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

>>> tb/sv/two_level_write_through_cache_tb.sv
`timescale 1ns / 1ps
module two_level_write_through_cache_tb;
	import tlc_pkg::*;

	localparam int MEM_BYTES = 1024;
	localparam int NEAR_SETS = 32;
	localparam int FAR_SETS = 128;
	localparam int NEAR_IDX_W = $clog2(NEAR_SETS);
	localparam int FAR_IDX_W = $clog2(FAR_SETS);
	localparam int HOT_COUNT = 16;

	// Shadow copy of the cache hierarchy; it predicts each access result and
	// keeps the predictions in arrival order.
	class cache_shadow;
		logic [DATA_W-1:0] mem_img [MEM_BYTES];
		bit near_ok [NEAR_SETS];
		logic [ADDR_W-NEAR_IDX_W-1:0] near_tag [NEAR_SETS];
		logic [DATA_W-1:0] near_byte [NEAR_SETS];
		bit far_ok [FAR_SETS];
		logic [ADDR_W-FAR_IDX_W-1:0] far_tag [FAR_SETS];
		logic [DATA_W-1:0] far_byte [FAR_SETS];
		logic [COST_W-1:0] hit_cost, miss_cost, write_cost, memory_cost;
		out_item_t due_results [$];
		int errors, checked, reads, writes, near_hits, far_hits, mem_fills;

		function new();
			foreach (mem_img[i]) mem_img[i] = '0;
			foreach (near_ok[i]) begin
				near_ok[i] = 1'b0;
				near_tag[i] = '0;
				near_byte[i] = '0;
			end
			foreach (far_ok[i]) begin
				far_ok[i] = 1'b0;
				far_tag[i] = '0;
				far_byte[i] = '0;
			end
			hit_cost = HIT_COST_RST;
			miss_cost = MISS_COST_RST;
			write_cost = WRITE_COST_RST;
			memory_cost = MEMORY_COST_RST;
		endfunction

		function void set_cost(logic [CFG_IDX_W-1:0] idx, logic [COST_W-1:0] val);
			case (idx)
				CFG_HIT_COST: hit_cost = val;
				CFG_MISS_COST: miss_cost = val;
				CFG_WRITE_COST: write_cost = val;
				CFG_MEMORY_COST: memory_cost = val;
				default: ;
			endcase
		endfunction

		function void note_access(in_item_t acc);
			logic [NEAR_IDX_W-1:0] ni;
			logic [ADDR_W-NEAR_IDX_W-1:0] nt;
			logic [FAR_IDX_W-1:0] fi;
			logic [ADDR_W-FAR_IDX_W-1:0] ft;
			bit near_hit, far_hit;
			int unsigned cost;
			out_item_t res;
			{nt, ni} = acc.address;
			{ft, fi} = acc.address;
			near_hit = near_ok[ni] && near_tag[ni] == nt;
			far_hit = far_ok[fi] && far_tag[fi] == ft;
			res = '0;
			res.first_hit = near_hit;
			if (acc.opcode == OP_READ) begin
				reads++;
				if (near_hit) begin
					res.read_data = near_byte[ni];
					cost = 32'(hit_cost);
				end else begin
					cost = 32'(miss_cost);
					if (far_hit) begin
						res.second_hit = 1'b1;
						res.read_data = far_byte[fi];
						cost += 32'(hit_cost);
					end else begin
						res.read_data = mem_img[acc.address];
						cost += 32'(miss_cost) + 32'(memory_cost);
						far_ok[fi] = 1'b1;
						far_tag[fi] = ft;
						far_byte[fi] = res.read_data;
						mem_fills++;
					end
					near_ok[ni] = 1'b1;
					near_tag[ni] = nt;
					near_byte[ni] = res.read_data;
				end
			end else begin
				// On a write the far level is looked up even when the near one hits.
				writes++;
				cost = 2 * 32'(write_cost);
				if (near_hit) begin
					near_byte[ni] = acc.write_data;
					cost += 32'(hit_cost);
				end
				if (far_hit) begin
					res.second_hit = 1'b1;
					far_byte[fi] = acc.write_data;
					cost += 32'(hit_cost);
				end
				mem_img[acc.address] = acc.write_data;
			end
			if (cost > 32'(LAT_MAX))
				cost = 32'(LAT_MAX);
			res.latency = cost[LAT_W-1:0];
			near_hits += int'(near_hit);
			far_hits += int'(res.second_hit);
			due_results.push_back(res);
		endfunction

		task report_mismatch(string msg);
			if (errors < 40)
				$display("MISMATCH @%0t: %s", $time, msg);
			errors++;
		endtask

		task check_result(out_item_t got);
			out_item_t want;
			if (due_results.size() == 0) begin
				report_mismatch($sformatf("result %h with nothing outstanding", got));
				return;
			end
			want = due_results.pop_front();
			checked++;
			if (got.read_data !== want.read_data)
				report_mismatch($sformatf("read_data %h, predicted %h",
					got.read_data, want.read_data));
			if (got.first_hit !== want.first_hit)
				report_mismatch($sformatf("first_hit %b, predicted %b",
					got.first_hit, want.first_hit));
			if (got.second_hit !== want.second_hit)
				report_mismatch($sformatf("second_hit %b, predicted %b",
					got.second_hit, want.second_hit));
			if (got.latency !== want.latency)
				report_mismatch($sformatf("latency %0d, predicted %0d",
					got.latency, want.latency));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_HIT_COST;
	logic [COST_W-1:0] cfg_data = '0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit rx_hold = 1'b0;
	logic [ADDR_W-1:0] hot_addr [HOT_COUNT];
	cache_shadow shadow;

	two_level_write_through_cache #(
		.MEM_DEPTH(MEM_BYTES),
		.NEAR_ENTRIES(NEAR_SETS),
		.FAR_ENTRIES(FAR_SETS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (rx_hold)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Both channels are sampled at the edge, before any testbench drive lands.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			shadow.note_access(in_data);
		if (arst_n && out_valid && out_ready)
			shadow.check_result(out_data);
	end

	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic send_access(logic op, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] wd);
		int gap;
		in_item_t acc;
		acc.opcode = op;
		acc.address = addr;
		acc.write_data = wd;
		gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 3) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= acc;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic wait_idle();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		@(posedge clk);
		while (shadow.due_results.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		if (shadow.due_results.size() != 0)
			shadow.report_mismatch($sformatf("%0d results never arrived",
				shadow.due_results.size()));
		repeat (8) @(posedge clk);
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [COST_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		shadow.set_cost(idx, val);
		@(posedge clk);
	endtask

	task automatic load_costs(logic [COST_W-1:0] h, logic [COST_W-1:0] m,
		logic [COST_W-1:0] w, logic [COST_W-1:0] mem);
		write_cfg(CFG_HIT_COST, h);
		write_cfg(CFG_MISS_COST, m);
		write_cfg(CFG_WRITE_COST, w);
		write_cfg(CFG_MEMORY_COST, mem);
		cfg_we <= 1'b0;
	endtask

	// Most addresses come from a small set that shares a few near indexes, so
	// hits, evictions and far-level refills happen often.
	task automatic run_random(int count, int idle_pct, int stall_pct);
		logic [NEAR_IDX_W-1:0] lo [4];
		logic [ADDR_W-1:0] addr;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		foreach (lo[i]) lo[i] = NEAR_IDX_W'($urandom_range(NEAR_SETS - 1));
		foreach (hot_addr[i])
			hot_addr[i] = {(ADDR_W - NEAR_IDX_W)'($urandom_range(
				2 ** (ADDR_W - NEAR_IDX_W) - 1)), lo[i % 4]};
		repeat (count) begin
			if ($urandom_range(99) < 65)
				addr = hot_addr[$urandom_range(HOT_COUNT - 1)];
			else
				addr = ADDR_W'($urandom_range(MEM_BYTES - 1));
			send_access($urandom_range(1) ? OP_WRITE : OP_READ, addr,
				DATA_W'($urandom_range(255)));
		end
	endtask

	task automatic hold_off_receiver(int cycles);
		rx_hold <= 1'b1;
		repeat (cycles) @(posedge clk);
		rx_hold <= 1'b0;
	endtask

	initial begin
		shadow = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed accesses at the reset costs; the block first runs its
		// clearing pass, which the handshake simply waits out.
		send_access(OP_READ, 10'd0, 8'h00);
		send_access(OP_READ, 10'd0, 8'h00);
		send_access(OP_WRITE, 10'd0, 8'hFF);
		send_access(OP_READ, 10'd0, 8'h00);
		send_access(OP_WRITE, 10'd1023, 8'hAA);
		send_access(OP_READ, 10'd1023, 8'hFF);
		send_access(OP_READ, 10'd32, 8'h00);
		send_access(OP_READ, 10'd0, 8'h00);
		send_access(OP_WRITE, 10'd32, 8'h55);
		send_access(OP_READ, 10'd32, 8'h00);
		send_access(OP_READ, 10'd128, 8'h00);
		send_access(OP_READ, 10'd0, 8'h00);
		send_access(OP_WRITE, 10'd0, 8'h00);
		send_access(OP_WRITE, 10'd512, 8'h7F);
		send_access(OP_READ, 10'd512, 8'h00);
		send_access(OP_READ, 10'd0, 8'h00);
		send_access(OP_WRITE, 10'd1, 8'h80);
		send_access(OP_READ, 10'd1, 8'h00);
		send_access(OP_WRITE, 10'd1023, 8'hFF);
		send_access(OP_READ, 10'd1023, 8'h00);
		send_access(OP_READ, 10'd895, 8'h00);
		send_access(OP_READ, 10'd1023, 8'h00);
		wait_idle();

		load_costs(8'd0, 8'd0, 8'd0, 8'd0);
		run_random(180, 0, 0);
		wait_idle();

		load_costs(8'd255, 8'd255, 8'd255, 8'd255);
		run_random(180, 52, 0);
		wait_idle();

		load_costs(COST_W'($urandom_range(255)), COST_W'($urandom_range(255)),
			COST_W'($urandom_range(255)), COST_W'($urandom_range(255)));
		run_random(180, 0, 52);
		wait_idle();

		load_costs(8'd255, 8'd0, 8'd255, 8'd0);
		run_random(180, 19, 19);
		wait_idle();

		// Keep the output blocked long enough that the block backs up and
		// stops taking input transfers, while the sender keeps offering.
		load_costs(COST_W'($urandom_range(255)), COST_W'($urandom_range(255)),
			COST_W'($urandom_range(255)), COST_W'($urandom_range(255)));
		fork
			hold_off_receiver(400);
			run_random(180, 0, 0);
		join
		wait_idle();

		$display("Covered %0d reads (%0d filled from memory) and %0d writes under six cost settings.",
			shadow.reads, shadow.mem_fills, shadow.writes);
		$display("Saw %0d near hits and %0d far hits; %0d results checked, %0d mismatches.",
			shadow.near_hits, shadow.far_hits, shadow.checked, shadow.errors);
		if (shadow.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> two_level_write_through_cache.f
sv/tlc_pkg.sv
sv/tlc_ram.sv
sv/tlc_ctrl.sv
sv/tlc_dp.sv
sv/two_level_write_through_cache.sv
tb/sv/two_level_write_through_cache_tb.sv
